FILE: hw/rtl/prqs_pkg.sv
// shared types and constants for the priority ready queue scheduler
// no dependencies; imported by prqs_queue and the scheduler top level
`default_nettype none

package prqs_pkg;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_RESUME  = 3'd1;
  localparam logic [2:0] OP_SUSPEND = 3'd2;
  localparam logic [2:0] OP_YIELD   = 3'd3;
  localparam logic [2:0] OP_SETPRIO = 3'd4;

  localparam logic [1:0] SLOT_FREE    = 2'd0;
  localparam logic [1:0] SLOT_SLEEP   = 2'd1;
  localparam logic [1:0] SLOT_READY   = 2'd2;
  localparam logic [1:0] SLOT_RUNNING = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_KILLED  = 2'd2;

  localparam logic [7:0] KILL_PRIO      = 8'd255;
  localparam logic [7:0] MAX_LIVE_PRIO  = 8'd254;
  localparam logic [7:0] RESET_DEF_PRIO = 8'd64;

  typedef enum logic [2:0] {
    QOP_INSERT = 3'b001,
    QOP_REMOVE = 3'b010,
    QOP_HEAD   = 3'b100
  } qop_t;

  typedef struct packed {
    logic start;
    qop_t op;
  } qcmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prqs_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prqs_queue.sv
// sorted ready queue engine: insert behind equals, remove by id, read head
// one entry compared per step; uses prqs_pkg and prqs_ram
`default_nettype none

module prqs_queue
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire qcmd_t                            cmd,
  input  wire logic [$clog2(MAX_THREADS)-1:0]   id,
  input  wire logic [7:0]                       prio,
  output logic                                  done,
  output logic [$clog2(MAX_THREADS+1)-1:0]      count,
  output logic [$clog2(MAX_THREADS)-1:0]        head_id,
  output logic [7:0]                            head_prio
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int ENT_W  = 8 + SLOT_W;

  typedef enum logic [7:0] {
    QS_IDLE     = 8'b0000_0001,
    QS_INS_RD   = 8'b0000_0010,
    QS_INS_CMP  = 8'b0000_0100,
    QS_INS_LAST = 8'b0000_1000,
    QS_REM_RD   = 8'b0001_0000,
    QS_REM_CMP  = 8'b0010_0000,
    QS_HEAD_RD  = 8'b0100_0000,
    QS_HEAD_CAP = 8'b1000_0000
  } qstate_t;

  qstate_t            state;
  logic [CNT_W-1:0]   idx;
  logic               found;
  logic [SLOT_W-1:0]  op_id;
  logic [7:0]         op_prio;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;
  logic [7:0]         rd_prio;
  logic [SLOT_W-1:0]  rd_id;
  logic [CNT_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   idx_dec;
  logic [CNT_W-1:0]   last;
  logic               hit;

  assign rd_prio = rd_data[ENT_W-1:SLOT_W];
  assign rd_id   = rd_data[SLOT_W-1:0];
  assign idx_inc = idx + CNT_W'(1);
  assign idx_dec = idx - CNT_W'(1);
  assign last    = count - CNT_W'(1);
  assign hit     = (rd_id == op_id);

  prqs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_THREADS)
  ) u_qram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {prio, id};
    case (state)
      QS_IDLE: begin
        if (cmd.start && cmd.op == QOP_INSERT && count == CNT_W'(0)) begin
          wr_en = 1'b1;
        end
      end
      QS_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc[SLOT_W-1:0];
        wr_data = (rd_prio > op_prio) ? rd_data : {op_prio, op_id};
      end
      QS_INS_LAST: begin
        wr_en   = 1'b1;
        wr_data = {op_prio, op_id};
      end
      QS_REM_CMP: begin
        wr_en   = found;
        wr_addr = idx_dec[SLOT_W-1:0];
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= QS_IDLE;
      count <= '0;
      done  <= 1'b0;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        QS_IDLE: begin
          if (cmd.start) begin
            op_id   <= id;
            op_prio <= prio;
            found   <= 1'b0;
            case (cmd.op)
              QOP_INSERT: begin
                if (count == CNT_W'(MAX_THREADS)) begin
                  done <= 1'b1;
                end else if (count == CNT_W'(0)) begin
                  count <= CNT_W'(1);
                  done  <= 1'b1;
                end else begin
                  idx   <= last;
                  state <= QS_INS_RD;
                end
              end
              QOP_REMOVE: begin
                if (count == CNT_W'(0)) begin
                  done <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= QS_REM_RD;
                end
              end
              QOP_HEAD: begin
                idx   <= '0;
                state <= QS_HEAD_RD;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        QS_INS_RD: begin
          state <= QS_INS_CMP;
        end
        QS_INS_CMP: begin
          if (rd_prio > op_prio) begin
            if (idx == CNT_W'(0)) begin
              state <= QS_INS_LAST;
            end else begin
              idx   <= idx_dec;
              state <= QS_INS_RD;
            end
          end else begin
            count <= count + CNT_W'(1);
            done  <= 1'b1;
            state <= QS_IDLE;
          end
        end
        QS_INS_LAST: begin
          count <= count + CNT_W'(1);
          done  <= 1'b1;
          state <= QS_IDLE;
        end
        QS_REM_RD: begin
          state <= QS_REM_CMP;
        end
        QS_REM_CMP: begin
          if (hit) begin
            found <= 1'b1;
          end
          if (idx == last) begin
            if (found || hit) begin
              count <= last;
            end
            done  <= 1'b1;
            state <= QS_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= QS_REM_RD;
          end
        end
        QS_HEAD_RD: begin
          state <= QS_HEAD_CAP;
        end
        QS_HEAD_CAP: begin
          head_id   <= rd_id;
          head_prio <= rd_prio;
          done      <= 1'b1;
          state     <= QS_IDLE;
        end
        default: begin
          state <= QS_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/priority_ready_queue_scheduler_unit.sv
// scheduler top level: sequencer and slot tables; uses prqs_pkg, prqs_queue and prqs_ram
// sequence: slot lookup and decide, then a head read for a yield, a remove that
//   walks every queued entry, an insert that compares entries from the tail, and a
//   final head read before the result; an unknown operation goes straight to the result
// throughput: one beat at a time; the next beat is taken the cycle after the result is loaded
// reset: synchronous; queue empty, all slots free, no running thread, default priority 64
`default_nettype none

module priority_ready_queue_scheduler_unit
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [2:0] operation,
  input  wire logic [3:0] thread_id,
  input  wire logic [7:0] new_priority,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [3:0]      running_id,
  output logic            running_valid,
  output logic            switched,
  output logic [7:0]      old_priority,
  output logic [1:0]      status
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int IDX_W  = (SLOT_W > 4) ? SLOT_W : 4;

  typedef enum logic [12:0] {
    S_IDLE        = 13'b0_0000_0000_0001,
    S_LOOK        = 13'b0_0000_0000_0010,
    S_DECIDE      = 13'b0_0000_0000_0100,
    S_YHEAD       = 13'b0_0000_0000_1000,
    S_YHEAD_WAIT  = 13'b0_0000_0001_0000,
    S_REMOVE      = 13'b0_0000_0010_0000,
    S_REMOVE_WAIT = 13'b0_0000_0100_0000,
    S_INSERT      = 13'b0_0000_1000_0000,
    S_INSERT_WAIT = 13'b0_0001_0000_0000,
    S_HEAD        = 13'b0_0010_0000_0000,
    S_HEAD_WAIT   = 13'b0_0100_0000_0000,
    S_CUR         = 13'b0_1000_0000_0000,
    S_OUT         = 13'b1_0000_0000_0000
  } state_t;

  state_t             state;
  logic [7:0]         default_priority;
  logic [2:0]         op_r;
  logic               tid_ok;
  logic [SLOT_W-1:0]  tid_r;
  logic [7:0]         np_r;
  logic [SLOT_W-1:0]  lk_addr;
  logic               st_vld;
  logic               p_valid;
  logic [SLOT_W-1:0]  p_id;
  logic               cur_valid;
  logic [SLOT_W-1:0]  cur_id;
  logic [7:0]         old_prio;
  logic [1:0]         res_code;
  logic               prev_fix;
  logic               ins_pending;
  logic [SLOT_W-1:0]  ins_id;
  logic [7:0]         ins_prio;
  logic [SLOT_W-1:0]  rem_id;
  logic [MAX_THREADS-1:0] slot_written;

  logic [IDX_W-1:0]   tid_ext;
  logic [SLOT_W-1:0]  tid_in;
  logic [IDX_W-1:0]   cur_ext;
  logic [7:0]         create_prio;
  logic [7:0]         prio_rd;
  logic [1:0]         st_raw;
  logic [1:0]         st_cur;
  logic               create_ok;
  logic               resume_ok;
  logic               suspend_ok;
  logic               kill;

  logic               st_we;
  logic [SLOT_W-1:0]  st_waddr;
  logic [1:0]         st_wdata;
  logic               pr_we;
  logic [SLOT_W-1:0]  pr_waddr;
  logic [7:0]         pr_wdata;

  qcmd_t              q_cmd;
  logic [SLOT_W-1:0]  q_id;
  logic               q_done;
  logic [CNT_W-1:0]   q_count;
  logic [SLOT_W-1:0]  q_head_id;
  logic [7:0]         q_head_prio;

  assign tid_ext     = IDX_W'(thread_id);
  assign tid_in      = tid_ext[SLOT_W-1:0];
  assign cur_ext     = IDX_W'(cur_id);
  assign create_prio = (default_priority == KILL_PRIO) ? MAX_LIVE_PRIO : default_priority;
  assign st_cur      = st_vld ? st_raw : SLOT_FREE;
  assign create_ok   = tid_ok && (st_cur == SLOT_FREE);
  assign resume_ok   = tid_ok && (st_cur == SLOT_SLEEP);
  assign suspend_ok  = tid_ok && (st_cur == SLOT_READY || st_cur == SLOT_RUNNING);
  assign kill        = (np_r == KILL_PRIO);
  assign item_stall  = rst || (state != S_IDLE);
  assign q_id        = (state == S_REMOVE) ? rem_id : ins_id;

  prqs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_THREADS)
  ) u_prio_ram (
    .clk     (clk),
    .wr_en   (pr_we),
    .wr_addr (pr_waddr),
    .wr_data (pr_wdata),
    .rd_addr (lk_addr),
    .rd_data (prio_rd)
  );

  prqs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_THREADS)
  ) u_stat_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (lk_addr),
    .rd_data (st_raw)
  );

  prqs_queue #(
    .MAX_THREADS (MAX_THREADS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .id        (q_id),
    .prio      (ins_prio),
    .done      (q_done),
    .count     (q_count),
    .head_id   (q_head_id),
    .head_prio (q_head_prio)
  );

  // queue engine commands
  always_comb begin
    q_cmd.start = 1'b0;
    q_cmd.op    = QOP_HEAD;
    case (state)
      S_YHEAD, S_HEAD: begin
        q_cmd.start = 1'b1;
        q_cmd.op    = QOP_HEAD;
      end
      S_REMOVE: begin
        q_cmd.start = 1'b1;
        q_cmd.op    = QOP_REMOVE;
      end
      S_INSERT: begin
        q_cmd.start = 1'b1;
        q_cmd.op    = QOP_INSERT;
      end
      default: begin
        q_cmd.start = 1'b0;
      end
    endcase
  end

  // slot table writes
  always_comb begin
    st_we    = 1'b0;
    st_waddr = tid_r;
    st_wdata = SLOT_READY;
    pr_we    = 1'b0;
    pr_waddr = tid_r;
    pr_wdata = create_prio;
    case (state)
      S_DECIDE: begin
        case (op_r)
          OP_CREATE: begin
            st_we = create_ok;
            pr_we = create_ok;
          end
          OP_RESUME: begin
            st_we = resume_ok;
          end
          OP_SUSPEND: begin
            st_we    = suspend_ok;
            st_wdata = SLOT_SLEEP;
          end
          OP_SETPRIO: begin
            st_we    = p_valid && kill;
            st_waddr = p_id;
            st_wdata = SLOT_FREE;
            pr_we    = p_valid;
            pr_waddr = p_id;
            pr_wdata = np_r;
          end
          default: begin
            st_we = 1'b0;
          end
        endcase
      end
      S_HEAD_WAIT: begin
        st_we    = q_done && prev_fix;
        st_waddr = p_id;
        st_wdata = SLOT_READY;
      end
      S_CUR: begin
        st_we    = (q_count != CNT_W'(0));
        st_waddr = q_head_id;
        st_wdata = SLOT_RUNNING;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      default_priority <= RESET_DEF_PRIO;
      cur_valid        <= 1'b0;
      cur_id           <= '0;
      slot_written     <= '0;
      result_valid     <= 1'b0;
      ins_pending      <= 1'b0;
      prev_fix         <= 1'b0;
    end else begin
      if (cfg_write) begin
        default_priority <= cfg_data;
      end
      if (st_we) begin
        slot_written[st_waddr] <= 1'b1;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op_r     <= operation;
            tid_ok   <= (32'(thread_id) < MAX_THREADS);
            tid_r    <= tid_in;
            np_r     <= new_priority;
            lk_addr  <= (operation == OP_SETPRIO) ? cur_id : tid_in;
            p_valid  <= cur_valid;
            p_id     <= cur_id;
            old_prio <= '0;
            res_code <= ST_DONE;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          st_vld <= slot_written[lk_addr];
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          prev_fix    <= p_valid;
          ins_pending <= 1'b0;
          ins_id      <= tid_r;
          rem_id      <= tid_r;
          state       <= S_HEAD;
          case (op_r)
            OP_CREATE: begin
              ins_prio <= create_prio;
              if (create_ok) begin
                state <= S_INSERT;
              end else begin
                res_code <= ST_IGNORED;
              end
            end
            OP_RESUME: begin
              ins_prio <= prio_rd;
              if (resume_ok) begin
                state <= S_INSERT;
              end else begin
                res_code <= ST_IGNORED;
              end
            end
            OP_SUSPEND: begin
              if (suspend_ok) begin
                state <= S_REMOVE;
                if (tid_r == p_id) begin
                  prev_fix <= 1'b0;
                end
              end else begin
                res_code <= ST_IGNORED;
              end
            end
            OP_YIELD: begin
              if (q_count > CNT_W'(1)) begin
                state <= S_YHEAD;
              end
            end
            OP_SETPRIO: begin
              if (p_valid) begin
                old_prio    <= prio_rd;
                rem_id      <= p_id;
                ins_id      <= p_id;
                ins_prio    <= np_r;
                ins_pending <= !kill;
                state       <= S_REMOVE;
                if (kill) begin
                  prev_fix <= 1'b0;
                  res_code <= ST_KILLED;
                end
              end else begin
                res_code <= ST_IGNORED;
              end
            end
            default: begin
              res_code <= ST_IGNORED;
              state    <= S_OUT;
            end
          endcase
        end
        S_YHEAD: begin
          state <= S_YHEAD_WAIT;
        end
        S_YHEAD_WAIT: begin
          if (q_done) begin
            rem_id      <= q_head_id;
            ins_id      <= q_head_id;
            ins_prio    <= q_head_prio;
            ins_pending <= 1'b1;
            state       <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          state <= S_REMOVE_WAIT;
        end
        S_REMOVE_WAIT: begin
          if (q_done) begin
            state <= ins_pending ? S_INSERT : S_HEAD;
          end
        end
        S_INSERT: begin
          state <= S_INSERT_WAIT;
        end
        S_INSERT_WAIT: begin
          if (q_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          if (q_done) begin
            state <= S_CUR;
          end
        end
        S_CUR: begin
          if (q_count != CNT_W'(0)) begin
            cur_id    <= q_head_id;
            cur_valid <= 1'b1;
          end else begin
            cur_id    <= '0;
            cur_valid <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            running_id    <= cur_ext[3:0];
            running_valid <= cur_valid;
            switched      <= (p_valid != cur_valid) || (cur_valid && (p_id != cur_id));
            old_priority  <= old_prio;
            status        <= res_code;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/priority_ready_queue_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for priority_ready_queue_scheduler_unit: directed table, then random runs
// predicts untyped dispatches with its own run-queue model; depends on prqs_pkg and the block rtl
module priority_ready_queue_scheduler_unit_tb
  import prqs_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int STUCK_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam int PHASE_BEATS = 270;

  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [3:0] running_id;
    logic       running_valid;
    logic       switched;
    logic [7:0] old_priority;
    logic [1:0] status;
  } dispatch_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICTED,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] op;
    logic [3:0] tid;
    logic [7:0] np;
    dispatch_t  want;
  } stim_row_t;

  localparam dispatch_t NO_OUTCOME = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       item_valid = 1'b0;
  logic [2:0] operation = 3'd0;
  logic [3:0] thread_id = 4'd0;
  logic [7:0] new_priority = 8'd0;
  logic       result_stall = 1'b0;
  logic       item_stall;
  logic       result_valid;
  logic [3:0] running_id;
  logic       running_valid;
  logic       switched;
  logic [7:0] old_priority;
  logic [1:0] status;

  // run-queue model state
  logic [3:0] rq_ids [SLOTS];
  int         rq_len;
  logic [7:0] slot_prio [SLOTS];
  logic [1:0] slot_state [SLOTS];
  logic [3:0] run_id;
  logic       run_valid;
  logic [7:0] def_prio;

  dispatch_t  dispatch_q [$];
  stim_row_t  dir_rows [$];
  int         fail_count = 0;
  int         stuck = 0;
  logic       steady = 1'b0;
  logic       sending = 1'b0;

  priority_ready_queue_scheduler_unit #(
    .MAX_THREADS(SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .thread_id    (thread_id),
    .new_priority (new_priority),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .running_id   (running_id),
    .running_valid(running_valid),
    .switched     (switched),
    .old_priority (old_priority),
    .status       (status)
  );

  always #5 clk = ~clk;

  function automatic void rq_insert(logic [3:0] id);
    int pos;
    if (rq_len >= SLOTS) return;
    pos = 0;
    while (pos < rq_len && slot_prio[rq_ids[pos]] <= slot_prio[id]) pos++;
    for (int i = rq_len; i > pos; i--) rq_ids[i] = rq_ids[i-1];
    rq_ids[pos] = id;
    rq_len++;
  endfunction

  function automatic void rq_remove(logic [3:0] id);
    for (int pos = 0; pos < rq_len; pos++) begin
      if (rq_ids[pos] == id) begin
        for (int i = pos; i < rq_len - 1; i++) rq_ids[i] = rq_ids[i+1];
        rq_len--;
        return;
      end
    end
  endfunction

  function automatic dispatch_t apply_sched_op(logic [2:0] op, logic [3:0] tid, logic [7:0] np);
    dispatch_t  r;
    logic       prev_valid;
    logic [3:0] prev_id;
    logic       resched;
    logic [3:0] head;
    r = '0;
    r.status = ST_DONE;
    prev_valid = run_valid;
    prev_id = run_id;
    resched = 1'b1;
    case (op)
      OP_CREATE: begin
        if (slot_state[tid] == SLOT_FREE) begin
          slot_prio[tid] = (def_prio == KILL_PRIO) ? MAX_LIVE_PRIO : def_prio;
          slot_state[tid] = SLOT_READY;
          rq_insert(tid);
        end else begin
          r.status = ST_IGNORED;
        end
      end
      OP_RESUME: begin
        if (slot_state[tid] == SLOT_SLEEP) begin
          slot_state[tid] = SLOT_READY;
          rq_insert(tid);
        end else begin
          r.status = ST_IGNORED;
        end
      end
      OP_SUSPEND: begin
        if (slot_state[tid] == SLOT_READY || slot_state[tid] == SLOT_RUNNING) begin
          rq_remove(tid);
          slot_state[tid] = SLOT_SLEEP;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      OP_YIELD: begin
        if (rq_len > 1) begin
          head = rq_ids[0];
          rq_remove(head);
          rq_insert(head);
        end
      end
      OP_SETPRIO: begin
        if (run_valid) begin
          r.old_priority = slot_prio[run_id];
          rq_remove(run_id);
          slot_prio[run_id] = np;
          if (np != KILL_PRIO) begin
            rq_insert(run_id);
          end else begin
            slot_state[run_id] = SLOT_FREE;
            r.status = ST_KILLED;
          end
        end else begin
          r.status = ST_IGNORED;
        end
      end
      default: begin
        r.status = ST_IGNORED;
        resched = 1'b0;
      end
    endcase
    if (resched) begin
      if (prev_valid && slot_state[prev_id] == SLOT_RUNNING) slot_state[prev_id] = SLOT_READY;
      if (rq_len > 0) begin
        run_id = rq_ids[0];
        run_valid = 1'b1;
        slot_state[run_id] = SLOT_RUNNING;
      end else begin
        run_id = 4'd0;
        run_valid = 1'b0;
      end
    end
    r.running_id = run_id;
    r.running_valid = run_valid;
    r.switched = (prev_valid != run_valid) || (run_valid && prev_id != run_id);
    return r;
  endfunction

  function automatic dispatch_t outcome(logic [3:0] rid, logic rv, logic sw, logic [7:0] oldp,
                                        logic [1:0] st);
    dispatch_t d;
    d.running_id = rid;
    d.running_valid = rv;
    d.switched = sw;
    d.old_priority = oldp;
    d.status = st;
    return d;
  endfunction

  function automatic void add_row(row_kind_t k, logic [2:0] op, logic [3:0] tid, logic [7:0] np,
                                  dispatch_t want);
    stim_row_t row;
    row.kind = k;
    row.op = op;
    row.tid = tid;
    row.np = np;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // random slot in state a or b, -1 if none
  function automatic int find_slot(logic [1:0] a, logic [1:0] b);
    int start;
    int s;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      s = (start + i) % SLOTS;
      if (slot_state[s] == a || slot_state[s] == b) return s;
    end
    return -1;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic hold_off();
    if (sending) begin
      item_valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic drain();
    hold_off();
    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_default_prio(input logic [7:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    def_prio = v;
  endtask

  task automatic send_item(input logic [2:0] op, input logic [3:0] tid, input logic [7:0] np,
                           input logic typed, input dispatch_t want);
    dispatch_t res;
    item_valid <= 1'b1;
    sending = 1'b1;
    operation <= op;
    thread_id <= tid;
    new_priority <= np;
    do @(posedge clk); while (item_stall !== 1'b0);
    res = apply_sched_op(op, tid, np);
    dispatch_q.push_back(typed ? want : res);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return;
    if (r < 2) begin
      drain();
    end else if (r < 35) begin
      hold_off();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    result_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    dispatch_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (dispatch_q.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(running_id), 0);
      end else begin
        want = dispatch_q.pop_front();
        if (running_id !== want.running_id)
          flag_mismatch("running_id", int'(running_id), int'(want.running_id));
        if (running_valid !== want.running_valid)
          flag_mismatch("running_valid", int'(running_valid), int'(want.running_valid));
        if (switched !== want.switched)
          flag_mismatch("switched", int'(switched), int'(want.switched));
        if (old_priority !== want.old_priority)
          flag_mismatch("old_priority", int'(old_priority), int'(want.old_priority));
        if (status !== want.status)
          flag_mismatch("status", int'(status), int'(want.status));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned total;
    int unsigned done;
    logic [7:0]  v;
    logic [2:0]  op;
    logic [3:0]  tid;
    logic [7:0]  np;
    int          r;
    int          s;

    rq_len = 0;
    run_id = 4'd0;
    run_valid = 1'b0;
    def_prio = RESET_DEF_PRIO;
    for (int i = 0; i < SLOTS; i++) begin
      rq_ids[i] = 4'd0;
      slot_prio[i] = 8'd0;
      slot_state[i] = SLOT_FREE;
    end

    // empty queue, wrong-state and reserved operations, then the first creates
    add_row(ROW_TYPED, OP_YIELD, 4'd0, 8'd0, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_DONE));
    add_row(ROW_TYPED, OP_SETPRIO, 4'd0, 8'd0, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_RESUME, 4'd15, 8'd0, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_SUSPEND, 4'd0, 8'd0, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_RSVD_5, 4'd15, 8'd255, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_RSVD_6, 4'd10, 8'haa, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_RSVD_7, 4'd5, 8'h55, outcome(4'd0, 1'b0, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_TYPED, OP_CREATE, 4'd0, 8'd0, outcome(4'd0, 1'b1, 1'b1, 8'd0, ST_DONE));
    add_row(ROW_TYPED, OP_CREATE, 4'd0, 8'd0, outcome(4'd0, 1'b1, 1'b0, 8'd0, ST_IGNORED));
    add_row(ROW_PREDICTED, OP_CREATE, 4'd15, 8'd0, NO_OUTCOME);
    // kill the running thread
    add_row(ROW_TYPED, OP_SETPRIO, 4'd0, KILL_PRIO,
            outcome(4'd15, 1'b1, 1'b1, RESET_DEF_PRIO, ST_KILLED));
    add_row(ROW_TYPED, OP_SETPRIO, 4'd0, 8'd0,
            outcome(4'd15, 1'b1, 1'b0, RESET_DEF_PRIO, ST_DONE));
    add_row(ROW_PREDICTED, OP_CREATE, 4'd3, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_CREATE, 4'd7, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_YIELD, 4'd0, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_SETPRIO, 4'd0, MAX_LIVE_PRIO, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_YIELD, 4'd0, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_SUSPEND, 4'd7, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_SUSPEND, 4'd15, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_RESUME, 4'd7, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_RESUME, 4'd7, 8'd0, NO_OUTCOME);
    // default priority at the kill level is clipped on create
    add_row(ROW_CFG, OP_CREATE, 4'd0, KILL_PRIO, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_CREATE, 4'd9, 8'd0, NO_OUTCOME);
    add_row(ROW_CFG, OP_CREATE, 4'd0, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_CREATE, 4'd10, 8'd0, NO_OUTCOME);
    add_row(ROW_PREDICTED, OP_SETPRIO, 4'd0, KILL_PRIO, NO_OUTCOME);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_default_prio(row.np);
      end else begin
        send_item(row.op, row.tid, row.np, row.kind == ROW_TYPED, row.want);
        idle_gap();
      end
    end

    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: v = MAX_LIVE_PRIO;
        1: v = 8'd0;
        2: v = KILL_PRIO;
        3: v = 8'd1;
        4: v = RESET_DEF_PRIO;
        default: v = 8'($urandom_range(0, 255));
      endcase
      write_default_prio(v);
      done = 0;
      while (done < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        tid = 4'($urandom_range(0, SLOTS - 1));
        np = 8'($urandom_range(0, 255));
        if (r < 22) begin
          op = OP_CREATE;
          s = find_slot(SLOT_FREE, SLOT_FREE);
          if (s >= 0 && $urandom_range(0, 9) < 8) tid = s[3:0];
        end else if (r < 40) begin
          op = OP_RESUME;
          s = find_slot(SLOT_SLEEP, SLOT_SLEEP);
          if (s >= 0 && $urandom_range(0, 9) < 8) tid = s[3:0];
        end else if (r < 55) begin
          op = OP_SUSPEND;
          s = find_slot(SLOT_READY, SLOT_RUNNING);
          if (s >= 0 && $urandom_range(0, 9) < 8) tid = s[3:0];
        end else if (r < 68) begin
          op = OP_YIELD;
        end else if (r < 94) begin
          op = OP_SETPRIO;
          s = $urandom_range(0, 99);
          if (s < 8) np = KILL_PRIO;
          else if (s < 30) np = 8'($urandom_range(0, 3));
          else if (s < 45) np = def_prio;
          else if (s < 60) np = MAX_LIVE_PRIO;
        end else begin
          op = OP_RSVD_5 + 3'($urandom_range(0, 2));
        end
        steady = (total >= 700 && total < 1000);
        send_item(op, tid, np, 1'b0, NO_OUTCOME);
        total++;
        done++;
        idle_gap();
      end
    end

    steady = 1'b0;
    hold_off();
    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
